>>> hdl/tpct_pkg.sv
`default_nettype none

package tpct_pkg;

    localparam int NODE_W  = 10;
    localparam int DEP_W   = 3;
    localparam int POS_W   = 10;
    localparam int CNT_W   = 32;
    localparam int DELTA_W = 17;
    localparam int LSZ_W   = 11;
    localparam int LEV_W   = 4;
    localparam int STEP_W  = 3;

    localparam logic [LSZ_W-1:0] LSIZE_MAX = 11'd2047;
    localparam int LEVELS_RST = 4;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_GROW   = 2'd1,
        KIND_ATTACH = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_ADD,
        S_GROW,
        S_ATT
    } t_state;

endpackage

`default_nettype wire

>>> hdl/tpct_ram.sv
`default_nettype none

module tpct_ram #(
    parameter int WIDTH = 55,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/tree_path_count_table.sv
// the first result word is registered from the head state, which reads the node's entry;
// for kind 2, and for kind 1 unless the table is full, it comes from the attach or grow
// state that follows; kind 0 does one read-modify-write per node on the path, kind 1 adds
// a fresh child per missing level, kind 3, a non-leaf or a full table end in the head state;
// a stalled result stalls the walk; after reset a clearing pass writes zero to every table
// entry, during which no input word is taken; the num_levels register resets to 4
`default_nettype none

module tree_path_count_table
    import tpct_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_LEVELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,    // num_levels
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // node_id, delta, new child, child position, pad
    input  wire logic [1:0]  s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // level, out_node, out_pos, pad
    output logic [0:0]       m_axis_tuser,   // error
    output logic             m_axis_tlast
);

    localparam int AW  = $clog2(MAX_NODES);
    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LHI = (MAX_LEVELS < 8) ? MAX_LEVELS : 8;
    localparam int LEV_RST = (LEVELS_RST > LHI) ? LHI : LEVELS_RST;

    typedef struct packed {
        logic [AW-1:0]           parent;
        logic [DEP_W-1:0]        dep;
        logic [POS_W-1:0]        pos;
        logic signed [CNT_W-1:0] cnt;
    } t_entry;

    localparam int EW = $bits(t_entry);

    t_state r_state, n_state;

    logic [1:0]                r_kind, n_kind;
    logic [NODE_W-1:0]         r_node, n_node;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic [NODE_W-1:0]         r_child, n_child;
    logic [POS_W-1:0]          r_cpos, n_cpos;
    logic [AW-1:0]             r_addr, n_addr;
    logic [STEP_W-1:0]         r_step, n_step;
    logic [AW-1:0]             r_cur, n_cur;
    logic [DEP_W-1:0]          r_cdep, n_cdep;
    logic [POS_W-1:0]          r_gpos, n_gpos;
    logic [DEP_W-1:0]          r_pd, n_pd;
    logic [AW:0]               r_next_free, n_next_free;
    logic [LSZ_W-1:0]          r_lsize [MAX_LEVELS];
    logic [LEV_W-1:0]          r_lev, n_lev;
    logic [AW-1:0]             r_clr, n_clr;
    logic                      r_fwd;
    t_entry                    r_fwd_data;

    logic             r_ovalid;
    logic [DEP_W-1:0] r_olevel;
    logic [NODE_W-1:0] r_onode;
    logic [POS_W-1:0] r_opos;
    logic             r_oerr;
    logic             r_olast;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_entry           ram_wdata;
    logic [EW-1:0]    ram_rdata;
    t_entry           ent;

    logic             ls_we;
    logic [LW-1:0]    ls_idx;
    logic [LSZ_W-1:0] ls_val;

    logic              emit;
    logic [DEP_W-1:0]  e_level;
    logic [NODE_W-1:0] e_node;
    logic [POS_W-1:0]  e_pos;
    logic              e_err;
    logic              e_last;

    logic              out_free;
    logic              in_acc;
    logic              node_oor;
    logic              child_oor;
    logic [DEP_W-1:0]  need;
    logic              grow_full;
    logic signed [CNT_W+1:0] sum;
    logic signed [CNT_W-1:0] sat;
    logic              walk_fin;
    logic [DEP_W-1:0]  gcd;
    logic [LW-1:0]     gidx;
    logic [DEP_W-1:0]  acd;
    logic [LW-1:0]     aidx;
    logic [AW:0]       child_end;
    logic [LSZ_W-1:0]  cpos_end;

    tpct_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_addr),
        .o_rdata (ram_rdata)
    );

    // a write to the entry being read at the same edge is taken from the write side
    assign ent = r_fwd ? r_fwd_data : t_entry'(ram_rdata);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_opos, r_onode, r_olevel};
    assign m_axis_tuser  = r_oerr;
    assign m_axis_tlast  = r_olast;

    assign node_oor  = (int'(r_node) >= MAX_NODES);
    assign child_oor = (int'(r_child) >= MAX_NODES);

    always_comb begin
        need = '0;
        if ({1'b0, ent.dep} + 4'd1 < r_lev) begin
            need = DEP_W'(r_lev - 4'd1 - {1'b0, ent.dep});
        end
    end
    assign grow_full = ({1'b0, r_next_free} + (AW+2)'(need)) > (AW+2)'(MAX_NODES);

    // saturating count update
    assign sum = (CNT_W+2)'(ent.cnt) + (CNT_W+2)'(r_delta);
    always_comb begin
        if (sum[CNT_W+1:CNT_W-1] == 3'b000 || sum[CNT_W+1:CNT_W-1] == 3'b111) begin
            sat = sum[CNT_W-1:0];
        end else if (sum[CNT_W+1]) begin
            sat = {1'b1, {(CNT_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(CNT_W-1){1'b1}}};
        end
    end
    assign walk_fin = (ent.dep == '0) || ({1'b0, r_step} + 4'd1 == r_lev);

    assign gcd       = r_cdep + 3'd1;
    assign gidx      = LW'(gcd);
    assign acd       = r_pd + 3'd1;
    assign aidx      = LW'(acd);
    assign child_end = (AW+1)'(r_child) + (AW+1)'(1);
    assign cpos_end  = {1'b0, r_cpos} + 11'd1;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_node      = r_node;
        n_delta     = r_delta;
        n_child     = r_child;
        n_cpos      = r_cpos;
        n_addr      = r_addr;
        n_step      = r_step;
        n_cur       = r_cur;
        n_cdep      = r_cdep;
        n_gpos      = r_gpos;
        n_pd        = r_pd;
        n_next_free = r_next_free;
        n_clr       = r_clr;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = ent;
        ls_we       = 1'b0;
        ls_idx      = gidx;
        ls_val      = '0;
        emit        = 1'b0;
        e_level     = '0;
        e_node      = '0;
        e_pos       = '0;
        e_err       = 1'b0;
        e_last      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_kind  = s_axis_tuser;
                    n_node  = s_axis_tdata[9:0];
                    n_delta = s_axis_tdata[26:10];
                    n_child = s_axis_tdata[36:27];
                    n_cpos  = s_axis_tdata[46:37];
                    n_addr  = AW'(s_axis_tdata[9:0]);
                    n_step  = '0;
                    n_state = S_HEAD;
                end
            end
            S_HEAD, S_ADD: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_err  = 1'b1;
                    e_last = 1'b1;
                    if (r_state == S_HEAD && r_kind == KIND_NONE) begin
                        n_state = S_IDLE;
                    end else if (r_state == S_HEAD &&
                                 (node_oor || (r_kind == KIND_ATTACH && child_oor))) begin
                        e_node  = r_node;
                        n_state = S_IDLE;
                    end else begin
                        case (t_kind'(r_kind))
                            KIND_ADD: begin
                                e_level = ent.dep;
                                e_pos   = ent.pos;
                                if (r_state == S_HEAD && {1'b0, ent.dep} + 4'd1 != r_lev) begin
                                    // not a leaf
                                    e_node  = r_node;
                                    n_state = S_IDLE;
                                end else begin
                                    ram_we        = 1'b1;
                                    ram_wdata.cnt = sat;
                                    e_node        = NODE_W'(r_addr);
                                    e_err         = 1'b0;
                                    e_last        = walk_fin;
                                    if (walk_fin) begin
                                        n_state = S_IDLE;
                                    end else begin
                                        n_addr  = ent.parent;
                                        n_step  = r_step + 1'b1;
                                        n_state = S_ADD;
                                    end
                                end
                            end
                            KIND_GROW: begin
                                if (grow_full) begin
                                    e_level = ent.dep;
                                    e_node  = r_node;
                                    e_pos   = ent.pos;
                                    n_state = S_IDLE;
                                end else begin
                                    emit    = 1'b0;
                                    n_cur   = r_addr;
                                    n_cdep  = ent.dep;
                                    n_gpos  = ent.pos;
                                    n_state = S_GROW;
                                end
                            end
                            KIND_ATTACH: begin
                                emit    = 1'b0;
                                n_pd    = ent.dep;
                                n_addr  = AW'(r_child);
                                n_state = S_ATT;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_GROW: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_level = r_cdep;
                    e_node  = NODE_W'(r_cur);
                    e_pos   = r_gpos;
                    if ({1'b0, r_cdep} + 4'd1 < r_lev) begin
                        // fresh child hangs below the current node
                        ram_we           = 1'b1;
                        ram_waddr        = r_next_free[AW-1:0];
                        ram_wdata.parent = r_cur;
                        ram_wdata.dep    = gcd;
                        ram_wdata.pos    = r_lsize[gidx][POS_W-1:0];
                        ram_wdata.cnt    = '0;
                        ls_we            = (r_lsize[gidx] < LSIZE_MAX);
                        ls_idx           = gidx;
                        ls_val           = r_lsize[gidx] + 11'd1;
                        n_cur            = r_next_free[AW-1:0];
                        n_cdep           = gcd;
                        n_gpos           = r_lsize[gidx][POS_W-1:0];
                        n_next_free      = r_next_free + 1'b1;
                    end else begin
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_ATT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    e_node  = r_child;
                    n_state = S_IDLE;
                    if (r_child == '0 || {1'b0, r_pd} + 4'd1 >= r_lev) begin
                        e_level = ent.dep;
                        e_pos   = ent.pos;
                        e_err   = 1'b1;
                    end else begin
                        ram_we           = 1'b1;
                        ram_wdata.parent = AW'(r_node);
                        ram_wdata.dep    = acd;
                        ram_wdata.pos    = r_cpos;
                        ls_we            = (cpos_end > r_lsize[aidx]);
                        ls_idx           = aidx;
                        ls_val           = cpos_end;
                        if (child_end > r_next_free) begin
                            n_next_free = child_end;
                        end
                        e_level = acd;
                        e_pos   = r_cpos;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_lev = r_lev;
        if (i_cfg_we) begin
            if (i_cfg_wdata < 4'd2) begin
                n_lev = 4'd2;
            end else if (int'(i_cfg_wdata) > LHI) begin
                n_lev = LEV_W'(LHI);
            end else begin
                n_lev = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= (AW+1)'(1);
            r_lev       <= LEV_W'(LEV_RST);
            r_ovalid    <= 1'b0;
            r_fwd       <= 1'b0;
            r_step      <= '0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_lsize[i] <= (i == 0) ? 11'd1 : 11'd0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            r_lev       <= n_lev;
            r_step      <= n_step;
            r_fwd       <= ram_we && (ram_waddr == n_addr);
            if (ls_we) begin
                r_lsize[ls_idx] <= ls_val;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_node     <= n_node;
        r_delta    <= n_delta;
        r_child    <= n_child;
        r_cpos     <= n_cpos;
        r_addr     <= n_addr;
        r_cur      <= n_cur;
        r_cdep     <= n_cdep;
        r_gpos     <= n_gpos;
        r_pd       <= n_pd;
        r_fwd_data <= ram_wdata;
        if (emit) begin
            r_olevel <= e_level;
            r_onode  <= e_node;
            r_opos   <= e_pos;
            r_oerr   <= e_err;
            r_olast  <= e_last;
        end
    end

endmodule

`default_nettype wire
